// File: src/assert_macros.svh
// Assertion helpers for the struct field packer checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is low.
`define SFP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define SFP_ASSERT_CLK(label, prop, msg) \
  `SFP_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// File: src/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants of the struct field packer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

  // Number of power-of-two gap classes (sizes 1 .. 2^(GAP_CLASSES-1)), 1 to 7
  localparam int unsigned GAP_CLASSES = 6;

  localparam int unsigned END_W   = 22;  // data section offsets in bits
  localparam int unsigned CNT_W   = 16;  // field and pointer counters
  localparam int unsigned BITS_W  = 11;  // field size
  localparam int unsigned ALIGN_W = 7;   // raw alignment
  localparam int unsigned LOG_W   = 3;   // log2 of effective alignment
  localparam int unsigned REM_W   = 7;   // gap remainders and padding (< 2^REM_W)
  localparam int unsigned KIND_W  = 2;

  localparam int unsigned S_TDATA_W = 40;  // 34 payload bits, zero filled
  localparam int unsigned S_TUSER_W = KIND_W;
  localparam int unsigned M_TDATA_W = 80;  // 76 payload bits, zero filled
  localparam int unsigned M_TUSER_W = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_VOID      = 2'd0,
    KIND_DATA      = 2'd1,
    KIND_PTR       = 2'd2,
    KIND_PTR_ARRAY = 2'd3
  } field_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input transaction
    logic decide;    // place the field, update counters, start gap recording
    logic rec_step;  // record one aligned gap
    logic load_out;  // load the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rec_done;  // no padding or remainder left to record
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/sfp_datapath.sv
// ----------------------------------------------------------------------------
// sfp_datapath
// Layout state, gap table, placement logic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sfp_pkg::dp_cmd_t               cmd_i,
  output sfp_pkg::dp_status_t                 status_o,
  input  wire logic [sfp_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  wire logic [sfp_pkg::S_TUSER_W-1:0]  s_tuser_i,
  output logic      [sfp_pkg::M_TDATA_W-1:0]  m_tdata_o,
  output logic      [sfp_pkg::M_TUSER_W-1:0]  m_tuser_o
);

  localparam int unsigned GC = sfp_pkg::GAP_CLASSES;
  localparam int unsigned EW = sfp_pkg::END_W;
  localparam int unsigned CW = sfp_pkg::CNT_W;
  localparam int unsigned BW = sfp_pkg::BITS_W;
  localparam int unsigned RW = sfp_pkg::REM_W;
  localparam int unsigned LW = sfp_pkg::LOG_W;

  // Index of the highest set bit, zero for zero
  function automatic logic [LW-1:0] floor_log2(input logic [sfp_pkg::ALIGN_W-1:0] a);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < sfp_pkg::ALIGN_W; i++) begin
      if (a[i]) r = LW'(i);
    end
    return r;
  endfunction

  // Captured transaction
  sfp_pkg::field_kind_e kind_q;
  logic [BW-1:0]        bits_q;
  logic [LW-1:0]        log_q;
  logic [CW-1:0]        slots_q;

  // Layout state
  logic [EW-1:0] data_end_q;
  logic [CW-1:0] dcount_q;
  logic [CW-1:0] pcount_q;
  logic [EW-1:0] gap_q [GC];

  // Gap recording walk
  logic [EW-1:0] rec_off_q;
  logic [RW-1:0] rec_size_q;

  // Result of the placement step
  logic [CW-1:0] res_slot_q;
  logic [EW-1:0] res_units_q;
  logic          res_ovf_q;

  // Output register
  logic [CW-1:0] out_slot_q;
  logic [EW-1:0] out_units_q;
  logic [EW-1:0] out_end_q;
  logic [CW-1:0] out_ptr_q;
  logic          out_ovf_q;

  // Smallest free gap that fits size and alignment
  logic [GC-1:0] claim_hit;
  logic [GC-1:0] claim_oh;
  logic          claim_any;
  logic [EW-1:0] claim_off;
  logic [RW-1:0] claim_gs;

  always_comb begin
    logic found;
    found     = 1'b0;
    claim_oh  = '0;
    claim_off = '0;
    claim_gs  = '0;
    for (int i = 0; i < GC; i++) begin
      claim_hit[i] = (gap_q[i] != '0) &&
                     ((BW+1)'(bits_q) <= ((BW+1)'(1) << i)) &&
                     (LW'(i) >= log_q);
    end
    for (int i = 0; i < GC; i++) begin
      if (claim_hit[i] && !found) begin
        claim_oh[i] = 1'b1;
        found       = 1'b1;
      end
    end
    for (int i = 0; i < GC; i++) begin
      if (claim_oh[i]) begin
        claim_off = claim_off | gap_q[i];
        claim_gs  = claim_gs | (RW'(1) << i);
      end
    end
    claim_any = found;
  end

  // Padding of the end up to the alignment, then append
  logic [EW-1:0] align_mask;
  logic [EW:0]   pad_sum;
  logic [EW:0]   padded;
  logic [EW:0]   pad_diff;
  logic [RW-1:0] pad_size;
  logic [EW+1:0] new_end;
  logic          end_ovf;

  assign align_mask = (EW'(1) << log_q) - EW'(1);
  assign pad_sum    = {1'b0, data_end_q} + {1'b0, align_mask};
  assign padded     = pad_sum & ~{1'b0, align_mask};
  assign pad_diff   = padded - {1'b0, data_end_q};
  assign pad_size   = pad_diff[RW-1:0];
  assign new_end    = {1'b0, padded} + (EW+2)'(bits_q);
  assign end_ovf    = (new_end[EW+1:EW] != 2'b00);

  // Data field decision
  logic          cnt_ovf;
  logic          data_ovf;
  logic [EW-1:0] data_off;
  logic [EW-1:0] data_units;

  assign cnt_ovf    = (dcount_q == {CW{1'b1}});
  assign data_ovf   = cnt_ovf || (!claim_any && end_ovf);
  assign data_off   = claim_any ? claim_off : padded[EW-1:0];
  assign data_units = data_off >> log_q;

  // Pointer decision
  logic [CW-1:0] ptr_n;
  logic [CW:0]   ptr_sum;
  logic          ptr_ovf;

  assign ptr_n   = (kind_q == sfp_pkg::KIND_PTR) ? CW'(1) : slots_q;
  assign ptr_sum = {1'b0, pcount_q} + {1'b0, ptr_n};
  assign ptr_ovf = ptr_sum[CW];

  // Per kind result
  logic          dec_ovf;
  logic [CW-1:0] dec_slot;
  logic [EW-1:0] dec_units;
  logic          data_ok;

  always_comb begin
    dec_ovf   = 1'b0;
    dec_slot  = '0;
    dec_units = '0;
    case (kind_q)
      sfp_pkg::KIND_PTR, sfp_pkg::KIND_PTR_ARRAY: begin
        dec_ovf  = ptr_ovf;
        dec_slot = ptr_ovf ? '0 : pcount_q;
      end
      sfp_pkg::KIND_DATA: begin
        dec_ovf = data_ovf;
        if (!data_ovf) begin
          dec_slot  = dcount_q;
          dec_units = data_units;
        end
      end
      default: ;
    endcase
  end

  assign data_ok = (kind_q == sfp_pkg::KIND_DATA) && !data_ovf;

  // Recording step: largest class that fits the rest and the offset alignment
  logic [GC-1:0] rec_oh;
  logic [RW-1:0] rec_gs;

  always_comb begin
    logic found;
    found  = 1'b0;
    rec_oh = '0;
    rec_gs = '0;
    for (int i = GC - 1; i >= 0; i--) begin
      if (!found && ((rec_size_q >> i) != '0) &&
          ((rec_off_q & ((EW'(1) << i) - EW'(1))) == '0)) begin
        rec_oh[i] = 1'b1;
        rec_gs    = RW'(1) << i;
        found     = 1'b1;
      end
    end
  end

  assign status_o.rec_done = (rec_size_q == '0);

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= sfp_pkg::field_kind_e'(s_tuser_i);
      bits_q  <= s_tdata_i[BW-1:0];
      log_q   <= floor_log2(s_tdata_i[BW+sfp_pkg::ALIGN_W-1:BW]);
      slots_q <= s_tdata_i[BW+sfp_pkg::ALIGN_W+CW-1:BW+sfp_pkg::ALIGN_W];
    end
  end

  // Layout state and gap table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_end_q <= '0;
      dcount_q   <= '0;
      pcount_q   <= '0;
      rec_size_q <= '0;
      for (int i = 0; i < GC; i++) gap_q[i] <= '0;
    end else if (cmd_i.decide) begin
      rec_size_q <= '0;
      if ((kind_q == sfp_pkg::KIND_PTR || kind_q == sfp_pkg::KIND_PTR_ARRAY) && !ptr_ovf) begin
        pcount_q <= ptr_sum[CW-1:0];
      end
      if (data_ok) begin
        dcount_q <= dcount_q + CW'(1);
        if (claim_any) begin
          rec_size_q <= claim_gs - RW'(bits_q);
          for (int i = 0; i < GC; i++) begin
            if (claim_oh[i]) gap_q[i] <= '0;
          end
        end else begin
          data_end_q <= new_end[EW-1:0];
          rec_size_q <= pad_size;
        end
      end
    end else if (cmd_i.rec_step) begin
      for (int i = 0; i < GC; i++) begin
        if (rec_oh[i]) gap_q[i] <= rec_off_q;
      end
      rec_size_q <= rec_size_q - rec_gs;
    end
  end

  // Recording offset and placement result
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      rec_off_q   <= claim_any ? claim_off + EW'(bits_q) : data_end_q;
      res_slot_q  <= dec_slot;
      res_units_q <= dec_units;
      res_ovf_q   <= dec_ovf;
    end else if (cmd_i.rec_step) begin
      rec_off_q <= rec_off_q + EW'(rec_gs);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_slot_q  <= res_slot_q;
      out_units_q <= res_units_q;
      out_end_q   <= data_end_q;
      out_ptr_q   <= pcount_q;
      out_ovf_q   <= res_ovf_q;
    end
  end

  assign m_tdata_o = {4'b0000, out_ptr_q, out_end_q, out_units_q, out_slot_q};
  assign m_tuser_o = out_ovf_q;

endmodule

`default_nettype wire

// File: src/sfp_ctrl.sv
// ----------------------------------------------------------------------------
// sfp_ctrl
// Sequencer: accept, place, record gaps, hand result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  output logic                     m_tvalid_o,
  input  wire logic                m_tready_i,
  output sfp_pkg::dp_cmd_t         cmd_o,
  input  wire sfp_pkg::dp_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RECORD,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   m_tvalid_q;
  logic   out_free;

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_tvalid_q;

  // Commands
  assign cmd_o.capture  = (state_q == ST_IDLE) && s_tvalid_i;
  assign cmd_o.decide   = (state_q == ST_DECIDE);
  assign cmd_o.rec_step = (state_q == ST_RECORD) && !status_i.rec_done;
  assign cmd_o.load_out = (state_q == ST_DONE) && out_free;

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state_q <= ST_RECORD;
        end
        ST_RECORD: begin
          if (status_i.rec_done) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cmd_o.load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/struct_field_packer_top.sv
// Steps: idle captures the input transaction, decide places the field, record walks
// the gaps (up to 6 per item) one at a time, and done loads the output register,
// waiting while it is full. A new item is accepted only in idle, after the gap walk.
// An item is accepted while the previous result still waits in the output register.
// Reset (rst_ni low, asynchronous) clears data end, counters and the gap table;
// the block is ready, in idle, as soon as reset is released.
// ----------------------------------------------------------------------------
// struct_field_packer_top
// Bit layout of record fields: pointer slots, data offsets and padding gap reuse.
// ----------------------------------------------------------------------------
`default_nettype none

module struct_field_packer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [10:0] field_bits, [17:11] align_bits, [33:18] pointer_slots, [39:34] zero
  input  wire logic [sfp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] field_kind
  input  wire logic [sfp_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [15:0] slot_index, [37:16] offset_units, [59:38] layout_end_bits,
  // [75:60] pointer_total, [79:76] zero
  output logic      [sfp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] overflow
  output logic      [sfp_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  sfp_pkg::dp_cmd_t    cmd;
  sfp_pkg::dp_status_t status;

  // Sequencer
  sfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // Layout datapath
  sfp_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: src/sfp_checker.sv
// ----------------------------------------------------------------------------
// sfp_checker
// Port level checks of the struct field packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [sfp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [sfp_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // One item in flight: ready drops after an input transaction
  `SFP_ASSERT_CLK(a_busy_after_accept, in_xfer |=> !s_axis_tready, "ready held after accept")

  // A new result appears only while the input side is busy
  `SFP_ASSERT_CLK(a_result_from_work, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without work")

  // Overflow results carry no slot and no offset
  `SFP_ASSERT_CLK(a_ovf_zero, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[37:0] == '0), "overflow with slot or offset")

  // Stalled result stays valid and stable
  `SFP_ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid, "valid dropped under stall")
  `SFP_ASSERT_CLK(a_out_stable, out_stall |=> $stable(m_axis_tdata), "data changed under stall")

endmodule

bind struct_field_packer_top sfp_checker u_sfp_checker (.*);

`default_nettype wire
